/* rtl/qmms_pkg.sv */
// ----------------------------------------------------------------------------
// qmms_pkg
// Shared types and constants for the quad motor mixer and smoother.
// ----------------------------------------------------------------------------
package qmms_pkg;

    // Width of a motor duty value and of the stored speeds
    localparam int DUTY_BITS  = 12;

    localparam int RAW_W      = 12;
    localparam int CORR_W     = 16;
    localparam int LIMIT_W    = 12;
    localparam int FACTOR_W   = 16;
    localparam int MASK_W     = 4;
    localparam int REQ_W      = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int MOTORS     = 4;
    localparam int MIDX_W     = $clog2(MOTORS);
    localparam int SM_CNT_W   = $clog2(MOTORS + 1);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_MIX    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STOP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DIRECT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RC_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING   = 2'd2;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 12'd750;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd9830;

    // RC throttle map: (raw - RC_LOW) * L / RC_SPAN
    localparam int RC_LOW   = 50;
    localparam int RC_SPAN  = 974;
    localparam int PROD_W   = RAW_W + LIMIT_W;      // (raw - 50) * L
    localparam int RECIP_SH = 34;
    localparam logic [24:0] RECIP = 25'd17638469;   // floor(2^34 / 974)
    localparam int Q_W      = 15;                   // quotient stays below 2^15

    // Shared multiplier operand width (signed)
    localparam int MUL_W    = 26;

    localparam int CMP_W    = (DUTY_BITS > Q_W) ? DUTY_BITS : Q_W;
    localparam int SUM_W    = ((DUTY_BITS + 4 > CORR_W) ? DUTY_BITS + 4 : CORR_W) + 3;
    localparam int NUM_W    = DUTY_BITS + FACTOR_W + 2;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic [RAW_W-1:0]         throttle_in;
        logic signed [CORR_W-1:0] roll_corr;
        logic signed [CORR_W-1:0] pitch_corr;
        logic signed [CORR_W-1:0] yaw_corr;
        logic [RAW_W-1:0]         direct_speed_1;
        logic [RAW_W-1:0]         direct_speed_2;
        logic [RAW_W-1:0]         direct_speed_3;
        logic [RAW_W-1:0]         direct_speed_4;
        logic [MASK_W-1:0]        motor_mask;
    } mix_in_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty_1;
        logic [DUTY_BITS-1:0] duty_2;
        logic [DUTY_BITS-1:0] duty_3;
        logic [DUTY_BITS-1:0] duty_4;
    } mix_out_t;

    // Controller to datapath
    typedef struct packed {
        logic              load_item;
        logic              thr_mul;
        logic              thr_div;
        logic              thr_fix;
        logic              mix;
        logic              sm_mul;
        logic [MIDX_W-1:0] sm_idx;
        logic              sm_wr;
        logic [MIDX_W-1:0] wr_idx;
        logic              direct;
        logic              rsp_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rc_mode;
        logic rsp_free;
    } dp_status_t;

endpackage

/* rtl/qmms_mul.sv */
// ----------------------------------------------------------------------------
// qmms_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module qmms_mul (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [qmms_pkg::MUL_W-1:0]   a,
    input  logic signed [qmms_pkg::MUL_W-1:0]   b,
    output logic signed [2*qmms_pkg::MUL_W-1:0] p
);
    import qmms_pkg::*;

    logic signed [2*MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

/* rtl/qmms_datapath.sv */
// ----------------------------------------------------------------------------
// qmms_datapath
// Config registers, throttle map, mixing, smoothing, speeds, result register.
// ----------------------------------------------------------------------------
module qmms_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  qmms_pkg::mix_in_t                req_data,
    input  logic                             cfg_we,
    input  logic [qmms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qmms_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  qmms_pkg::dp_cmd_t                cmd,
    output qmms_pkg::dp_status_t             status,
    input  logic                             rsp_stall,
    output logic                             rsp_valid,
    output qmms_pkg::mix_out_t               rsp_data
);
    import qmms_pkg::*;

    localparam logic [CMP_W-1:0] DUTY_MAX_C = CMP_W'((1 << DUTY_BITS) - 1);

    // config
    logic [LIMIT_W-1:0]   speed_limit_reg;
    logic                 rc_mode_reg;
    logic [FACTOR_W-1:0]  factor_reg;

    mix_in_t              item_reg;
    logic [PROD_W-1:0]    x_reg;
    logic [Q_W-1:0]       quot_reg;
    logic [Q_W-1:0]       quot_next;
    logic [DUTY_BITS-1:0] tgt_reg   [MOTORS];
    logic [DUTY_BITS-1:0] speed_reg [MOTORS];
    logic [DUTY_BITS-1:0] cur_reg;
    logic                 rsp_valid_reg;
    mix_out_t             rsp_data_reg;

    logic [DUTY_BITS-1:0] lim;
    logic [CMP_W-1:0]     lim_w;
    logic [RAW_W-1:0]     raw_off;

    logic                      mul_en;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] p_reg;

    logic [Q_W-1:0]       q0;
    logic [PROD_W:0]      qm;
    logic [PROD_W:0]      rem;

    logic [DUTY_BITS-1:0]    thr;
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] top;
    logic signed [SUM_W-1:0] r_c;
    logic signed [SUM_W-1:0] p_c;
    logic signed [SUM_W-1:0] y_c;
    logic signed [SUM_W-1:0] mix_sum [MOTORS];

    logic [DUTY_BITS-1:0]      cur_sel;
    logic [DUTY_BITS-1:0]      tgt_sel;
    logic signed [DUTY_BITS:0] diff;
    logic signed [NUM_W-1:0]   num;
    logic [DUTY_BITS:0]        v;
    logic [DUTY_BITS-1:0]      smooth_val;

    logic [RAW_W-1:0]     dsrc   [MOTORS];
    logic [DUTY_BITS-1:0] dclamp [MOTORS];

    function automatic logic [DUTY_BITS-1:0] clamp_tgt(
        input logic signed [SUM_W-1:0] s,
        input logic signed [SUM_W-1:0] hi
    );
        logic signed [SUM_W-1:0] c;
        begin
            c = s;
            if (s < 0)
            begin
                c = '0;
            end
            else if (s > hi)
            begin
                c = hi;
            end
            return c[DUTY_BITS+3:4];
        end
    endfunction

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= LIMIT_RESET;
            rc_mode_reg     <= 1'b0;
            factor_reg      <= FACTOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SPEED_LIMIT: speed_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_RC_MODE:     rc_mode_reg     <= cfg_data[0];
                CFG_SMOOTHING:   factor_reg      <= cfg_data[FACTOR_W-1:0];
                default:         ;
            endcase
        end
    end

    // effective limit
    always_comb
    begin
        if (CMP_W'(speed_limit_reg) > DUTY_MAX_C)
        begin
            lim = DUTY_BITS'(DUTY_MAX_C);
        end
        else
        begin
            lim = DUTY_BITS'(CMP_W'(speed_limit_reg));
        end
    end

    assign lim_w   = CMP_W'(lim);
    assign raw_off = item_reg.throttle_in - RAW_W'(RC_LOW);

    // ---- item latch ----
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req_data;
        end
    end

    // ---- shared multiplier ----
    assign cur_sel = speed_reg[cmd.sm_idx];
    assign tgt_sel = tgt_reg[cmd.sm_idx];
    assign diff    = signed'({1'b0, tgt_sel}) - signed'({1'b0, cur_sel});

    always_comb
    begin
        mul_en = cmd.thr_mul | cmd.thr_div | cmd.sm_mul;
        mul_a  = '0;
        mul_b  = '0;
        if (cmd.thr_mul)
        begin
            mul_a = MUL_W'(raw_off);
            mul_b = MUL_W'(lim);
        end
        else if (cmd.thr_div)
        begin
            mul_a = MUL_W'(p_reg[PROD_W-1:0]);
            mul_b = MUL_W'(RECIP);
        end
        else if (cmd.sm_mul)
        begin
            mul_a = MUL_W'(diff);
            mul_b = MUL_W'(factor_reg);
        end
    end

    qmms_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (p_reg)
    );

    // ---- divide by 974: reciprocal estimate, one correction ----
    assign q0        = p_reg[RECIP_SH +: Q_W];
    assign qm        = (PROD_W+1)'(q0) * (PROD_W+1)'(RC_SPAN);
    assign rem       = {1'b0, x_reg} - qm;
    assign quot_next = (rem >= (PROD_W+1)'(RC_SPAN)) ? q0 + Q_W'(1) : q0;

    always_ff @(posedge clk)
    begin
        if (cmd.thr_div)
        begin
            x_reg <= p_reg[PROD_W-1:0];
        end
        if (cmd.thr_fix)
        begin
            quot_reg <= quot_next;
        end
    end

    // ---- throttle and mixing ----
    always_comb
    begin
        thr = '0;
        if (item_reg.req_type == REQ_MIX)
        begin
            if (rc_mode_reg)
            begin
                if (item_reg.throttle_in < RAW_W'(RC_LOW))
                begin
                    thr = '0;
                end
                else if (CMP_W'(quot_reg) > lim_w)
                begin
                    thr = lim;
                end
                else
                begin
                    thr = DUTY_BITS'(CMP_W'(quot_reg));
                end
            end
            else if (CMP_W'(item_reg.throttle_in) > lim_w)
            begin
                thr = lim;
            end
            else
            begin
                thr = DUTY_BITS'(CMP_W'(item_reg.throttle_in));
            end
        end
    end

    assign base = signed'(SUM_W'({thr, 4'b0000}));
    assign top  = signed'(SUM_W'({lim, 4'b0000}));
    assign r_c  = SUM_W'(item_reg.roll_corr);
    assign p_c  = SUM_W'(item_reg.pitch_corr);
    assign y_c  = SUM_W'(item_reg.yaw_corr);

    // X frame signs
    assign mix_sum[0] = base - r_c + p_c - y_c;
    assign mix_sum[1] = base + r_c + p_c + y_c;
    assign mix_sum[2] = base + r_c - p_c - y_c;
    assign mix_sum[3] = base - r_c - p_c + y_c;

    always_ff @(posedge clk)
    begin
        if (cmd.mix)
        begin
            for (int i = 0; i < MOTORS; i++)
            begin
                tgt_reg[i] <= (thr == '0) ? '0 : clamp_tgt(mix_sum[i], top);
            end
        end
        if (cmd.sm_mul)
        begin
            cur_reg <= cur_sel;
        end
    end

    // ---- smoothing write-back: cur + f*(tgt-cur)/2^16, floor, clamped to [0, limit] ----
    assign num = signed'(NUM_W'({cur_reg, {FACTOR_W{1'b0}}})) + signed'(p_reg[NUM_W-1:0]);
    assign v   = num[FACTOR_W +: DUTY_BITS+1];

    always_comb
    begin
        if (num < 0)
        begin
            smooth_val = '0;
        end
        else if (v > {1'b0, lim})
        begin
            smooth_val = lim;
        end
        else
        begin
            smooth_val = v[DUTY_BITS-1:0];
        end
    end

    // ---- direct write ----
    assign dsrc[0] = item_reg.direct_speed_1;
    assign dsrc[1] = item_reg.direct_speed_2;
    assign dsrc[2] = item_reg.direct_speed_3;
    assign dsrc[3] = item_reg.direct_speed_4;

    always_comb
    begin
        for (int i = 0; i < MOTORS; i++)
        begin
            if (CMP_W'(dsrc[i]) > lim_w)
            begin
                dclamp[i] = lim;
            end
            else
            begin
                dclamp[i] = DUTY_BITS'(CMP_W'(dsrc[i]));
            end
        end
    end

    // ---- motor speeds ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOTORS; i++)
            begin
                speed_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < MOTORS; i++)
            begin
                if (cmd.sm_wr && (cmd.wr_idx == MIDX_W'(i)))
                begin
                    speed_reg[i] <= smooth_val;
                end
                else if (cmd.direct && item_reg.motor_mask[i])
                begin
                    speed_reg[i] <= dclamp[i];
                end
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
        begin
            rsp_data_reg.duty_1 <= speed_reg[0];
            rsp_data_reg.duty_2 <= speed_reg[1];
            rsp_data_reg.duty_3 <= speed_reg[2];
            rsp_data_reg.duty_4 <= speed_reg[3];
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign rsp_data         = rsp_data_reg;
    assign status.rc_mode   = rc_mode_reg;
    assign status.rsp_free  = !rsp_valid_reg || !rsp_stall;

    // ---- checks ----
    a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.thr_fix |=>
            (((PROD_W+1)'(quot_reg) * (PROD_W+1)'(RC_SPAN)) <= {1'b0, x_reg}) &&
            (({1'b0, x_reg} - (PROD_W+1)'(quot_reg) * (PROD_W+1)'(RC_SPAN))
                < (PROD_W+1)'(RC_SPAN)))
        else $error("throttle quotient off by more than the correction");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_load |-> (!rsp_valid_reg || !rsp_stall))
        else $error("result register overwritten while held");

    a_rsp_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_load |=> rsp_valid_reg && (rsp_data_reg.duty_1 == $past(speed_reg[0]))
                         && (rsp_data_reg.duty_4 == $past(speed_reg[3])))
        else $error("result does not match stored speeds");

endmodule

/* rtl/qmms_ctrl.sv */
// ----------------------------------------------------------------------------
// qmms_ctrl
// Sequencer: throttle map, mix, four smoothing steps, direct write, result transfer.
// ----------------------------------------------------------------------------
module qmms_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic [qmms_pkg::REQ_W-1:0]    req_type,
    output logic                          req_stall,
    input  qmms_pkg::dp_status_t          status,
    output qmms_pkg::dp_cmd_t             cmd
);
    import qmms_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_THR_MUL = 8'b0000_0010,
        S_THR_DIV = 8'b0000_0100,
        S_THR_FIX = 8'b0000_1000,
        S_MIX     = 8'b0001_0000,
        S_SMOOTH  = 8'b0010_0000,
        S_DIRECT  = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    localparam logic [SM_CNT_W-1:0] SM_LAST = SM_CNT_W'(MOTORS);

    state_t              state_reg;
    state_t              state_next;
    logic [SM_CNT_W-1:0] cnt_reg;
    logic [SM_CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    unique case (req_type)
                        REQ_MIX:    state_next = status.rc_mode ? S_THR_MUL : S_MIX;
                        REQ_STOP:   state_next = S_MIX;
                        REQ_DIRECT: state_next = S_DIRECT;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_THR_MUL:
            begin
                cmd.thr_mul = 1'b1;
                state_next  = S_THR_DIV;
            end
            S_THR_DIV:
            begin
                cmd.thr_div = 1'b1;
                state_next  = S_THR_FIX;
            end
            S_THR_FIX:
            begin
                cmd.thr_fix = 1'b1;
                state_next  = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                cnt_next   = '0;
                state_next = S_SMOOTH;
            end
            S_SMOOTH:
            begin
                // multiply motor n while writing back motor n-1
                if (cnt_reg != SM_LAST)
                begin
                    cmd.sm_mul = 1'b1;
                    cmd.sm_idx = cnt_reg[MIDX_W-1:0];
                end
                if (cnt_reg != '0)
                begin
                    cmd.sm_wr  = 1'b1;
                    cmd.wr_idx = MIDX_W'(cnt_reg - SM_CNT_W'(1));
                end
                if (cnt_reg == SM_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + SM_CNT_W'(1);
                end
            end
            S_DIRECT:
            begin
                cmd.direct = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.rsp_free)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("transfer accepted but sequencer stayed idle");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SMOOTH) |-> (cnt_reg <= SM_LAST))
        else $error("smoothing counter out of range");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_load |-> (state_reg == S_DONE) && status.rsp_free)
        else $error("result loaded outside the done state");

endmodule

/* rtl/quad_motor_mixer_smoother_core.sv */
// ----------------------------------------------------------------------------
// quad_motor_mixer_smoother_core
// Four-motor X-frame mixer with exponential speed smoothing.
// ----------------------------------------------------------------------------
// Sequence to result valid: mix, smoothing, done for a mixed update or stop;
//   throttle multiply, divide and fix first in RC mode; direct then done for a
//   direct write; straight to done for code 3. Done waits for a free result.
// Flow: one item at a time; the four smoothing steps share the one multiplier.
// Reset: asynchronous, active low; speeds clear to zero, registers to
//   limit 750, RC mode off, smoothing factor 9830. No clearing pass.
// ----------------------------------------------------------------------------
module quad_motor_mixer_smoother_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             req_valid,
    output logic                             req_stall,
    input  qmms_pkg::mix_in_t                req_data,
    // result channel
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output qmms_pkg::mix_out_t               rsp_data,
    // configuration writes
    input  logic                             cfg_we,
    input  logic [qmms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qmms_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import qmms_pkg::*;

    // The controller walks each item through the datapath:
    //   RC mode only: (raw-50)*L, times reciprocal of 974, one correction.
    //   Mix: throttle clamp and the four X-frame sums, clamped and >>4.
    //   Smooth: one motor per cycle through the shared multiplier, the
    //   write-back of motor n overlapping the multiply of motor n+1.
    //   Done: waits for the result register to be free, then loads it.
    // The result register sits in the datapath, so a new request transfer
    // is taken while the previous result is still held by a stalled sink.

    dp_cmd_t    cmd;
    dp_status_t status;

    qmms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_data.req_type),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    qmms_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

endmodule
